// File: rtl/cpt_pkg.sv
// Shared widths, region codes and stage types for the closest-point pipeline.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

    localparam int CW    = 32;          // coordinate width, signed
    localparam int DF_W  = CW + 1;      // vertex differences
    localparam int PR_W  = 2 * DF_W;    // one term of a dot product
    localparam int DOT_W = PR_W + 2;    // d1..d6
    localparam int DD_W  = DOT_W + 1;   // differences of two d terms
    localparam int DM_W  = DOT_W - 2;   // |d| always fits here
    localparam int LB    = 22;          // limb of |d| for the area products
    localparam int NLB   = DM_W / LB;
    localparam int LPP_W = 2 * LB;
    localparam int VP_W  = 2 * DM_W;    // |d*d|
    localparam int V_W   = VP_W + 4;    // va, vb, vc
    localparam int SC_W  = V_W;         // scalar factor of the numerator
    localparam int SCL   = 34;          // limb of |scalar|
    localparam int NSC   = SC_W / SCL;
    localparam int SPP_W = DF_W + SCL;
    localparam int SP_W  = DF_W + SC_W; // |vector * scalar|
    localparam int NUM_W = SP_W + 2;    // numerator, signed
    localparam int DEN_W = V_W;         // divisor, signed
    localparam int DQ_W  = DEN_W + 1;   // 2*|den|
    localparam int QB    = 35;          // quotient magnitude bits
    localparam int R_W   = NUM_W + 2;   // 2*|num| + |den|
    localparam int OS_W  = QB + 4;      // base plus signed quotient

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [2:0] REG_VA   = 3'd0;
    localparam logic [2:0] REG_VB   = 3'd1;
    localparam logic [2:0] REG_AB   = 3'd2;
    localparam logic [2:0] REG_VC   = 3'd3;
    localparam logic [2:0] REG_AC   = 3'd4;
    localparam logic [2:0] REG_BC   = 3'd5;
    localparam logic [2:0] REG_FACE = 3'd6;

    typedef logic [2:0][CW-1:0]   cvec_t;
    typedef logic [2:0][DF_W-1:0] dvec_t;

    typedef struct packed {
        dvec_t ab;
        dvec_t ac;
        dvec_t bc;
        cvec_t a;
        cvec_t b;
        cvec_t c;
    } geo_t;

    typedef struct packed {
        logic [5:0][DOT_W-1:0] d;
        geo_t                  g;
    } dots_t;

    typedef struct packed {
        logic [5:0][DOT_W-1:0] d;
        logic [V_W-1:0]        va;
        logic [V_W-1:0]        vb;
        logic [V_W-1:0]        vc;
        logic [DD_W-1:0]       t;   // d4 - d3
        logic [DD_W-1:0]       s;   // d5 - d6
        logic [DD_W-1:0]       u;   // d1 - d3
        logic [DD_W-1:0]       w;   // d2 - d6
        geo_t                  g;
    } areas_t;

    typedef struct packed {
        logic [2:0][R_W-1:0] r;
        logic [2:0][QB-1:0]  q;
        logic [DQ_W-1:0]     dq;
        logic [2:0]          neg;
        logic [2:0]          ovf;
        cvec_t               base;
        logic [2:0]          region;
        logic                divide;
        logic                degen;
    } div_t;

    typedef struct packed {
        cvec_t      near;
        logic [2:0] region;
        logic       in_face;
        logic       degen;
    } res_t;

endpackage
`default_nettype wire

// File: rtl/cpt_dots.sv
// Stages 1-3: edge vectors, dot-product terms and the six dot products.
`timescale 1ns / 1ps
`default_nettype none
module cpt_dots
    import cpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  cvec_t p,
    input  cvec_t a,
    input  cvec_t b,
    input  cvec_t c,
    output logic  out_valid,
    output dots_t dout
);

    geo_t  g1_next;
    geo_t  g1_reg;
    geo_t  g2_reg;
    geo_t  g3_reg;
    dvec_t ap_next;
    dvec_t bp_next;
    dvec_t cp_next;
    dvec_t ap_reg;
    dvec_t bp_reg;
    dvec_t cp_reg;
    logic [5:0][2:0][PR_W-1:0] pr_next;
    logic [5:0][2:0][PR_W-1:0] pr_reg;
    logic [5:0][DOT_W-1:0]     d_next;
    logic [5:0][DOT_W-1:0]     d_reg;
    logic [2:0]                vld_reg;

    always_comb
    begin
        g1_next.a = a;
        g1_next.b = b;
        g1_next.c = c;
        for (int k = 0; k < 3; k++)
        begin
            g1_next.ab[k] = {b[k][CW-1], b[k]} - {a[k][CW-1], a[k]};
            g1_next.ac[k] = {c[k][CW-1], c[k]} - {a[k][CW-1], a[k]};
            g1_next.bc[k] = {c[k][CW-1], c[k]} - {b[k][CW-1], b[k]};
            ap_next[k]    = {p[k][CW-1], p[k]} - {a[k][CW-1], a[k]};
            bp_next[k]    = {p[k][CW-1], p[k]} - {b[k][CW-1], b[k]};
            cp_next[k]    = {p[k][CW-1], p[k]} - {c[k][CW-1], c[k]};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr_next[0][k] = $signed(g1_reg.ab[k]) * $signed(ap_reg[k]);
            pr_next[1][k] = $signed(g1_reg.ac[k]) * $signed(ap_reg[k]);
            pr_next[2][k] = $signed(g1_reg.ab[k]) * $signed(bp_reg[k]);
            pr_next[3][k] = $signed(g1_reg.ac[k]) * $signed(bp_reg[k]);
            pr_next[4][k] = $signed(g1_reg.ab[k]) * $signed(cp_reg[k]);
            pr_next[5][k] = $signed(g1_reg.ac[k]) * $signed(cp_reg[k]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            d_next[j] = DOT_W'($signed(pr_reg[j][0])) + DOT_W'($signed(pr_reg[j][1]))
                      + DOT_W'($signed(pr_reg[j][2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg <= g1_next;
            ap_reg <= ap_next;
            bp_reg <= bp_next;
            cp_reg <= cp_next;
            g2_reg <= g1_reg;
            pr_reg <= pr_next;
            g3_reg <= g2_reg;
            d_reg  <= d_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign dout.d    = d_reg;
    assign dout.g    = g3_reg;

endmodule
`default_nettype wire

// File: rtl/cpt_areas.sv
// Stages 4-6: limb products of dot pairs and the signed areas va, vb, vc.
`timescale 1ns / 1ps
`default_nettype none
module cpt_areas
    import cpt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  dots_t  din,
    output logic   out_valid,
    output areas_t dout
);

    // operand pairs: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

    logic [5:0][NLB*NLB-1:0][LPP_W-1:0] lp_next;
    logic [5:0][NLB*NLB-1:0][LPP_W-1:0] lp_reg;
    logic [5:0]                         sg_next;
    logic [5:0]                         sg_reg;
    logic [5:0][V_W-1:0]                pv_next;
    logic [5:0][V_W-1:0]                pv_reg;
    dots_t                              c4_reg;
    dots_t                              c5_reg;
    areas_t                             ar_next;
    areas_t                             ar_reg;
    logic [2:0]                         vld_reg;

    always_comb
    begin
        logic [DOT_W-1:0] xa;
        logic [DOT_W-1:0] xb;
        logic [DM_W-1:0]  ma;
        logic [DM_W-1:0]  mb;
        for (int m = 0; m < 6; m++)
        begin
            xa         = din.d[PA[m]];
            xb         = din.d[PB[m]];
            ma         = DM_W'(xa[DOT_W-1] ? -xa : xa);
            mb         = DM_W'(xb[DOT_W-1] ? -xb : xb);
            sg_next[m] = xa[DOT_W-1] ^ xb[DOT_W-1];
            for (int i = 0; i < NLB; i++)
            begin
                for (int j = 0; j < NLB; j++)
                begin
                    lp_next[m][i*NLB+j] = LPP_W'(ma[i*LB +: LB]) * LPP_W'(mb[j*LB +: LB]);
                end
            end
        end
    end

    always_comb
    begin
        logic [VP_W-1:0] acc;
        for (int m = 0; m < 6; m++)
        begin
            acc = '0;
            for (int i = 0; i < NLB; i++)
            begin
                for (int j = 0; j < NLB; j++)
                begin
                    acc = acc + (VP_W'(lp_reg[m][i*NLB+j]) << (LB * (i + j)));
                end
            end
            pv_next[m] = sg_reg[m] ? -V_W'(acc) : V_W'(acc);
        end
    end

    always_comb
    begin
        ar_next.d  = c5_reg.d;
        ar_next.g  = c5_reg.g;
        ar_next.vc = pv_reg[0] - pv_reg[1];
        ar_next.vb = pv_reg[2] - pv_reg[3];
        ar_next.va = pv_reg[4] - pv_reg[5];
        ar_next.t  = {c5_reg.d[3][DOT_W-1], c5_reg.d[3]} - {c5_reg.d[2][DOT_W-1], c5_reg.d[2]};
        ar_next.s  = {c5_reg.d[4][DOT_W-1], c5_reg.d[4]} - {c5_reg.d[5][DOT_W-1], c5_reg.d[5]};
        ar_next.u  = {c5_reg.d[0][DOT_W-1], c5_reg.d[0]} - {c5_reg.d[2][DOT_W-1], c5_reg.d[2]};
        ar_next.w  = {c5_reg.d[1][DOT_W-1], c5_reg.d[1]} - {c5_reg.d[5][DOT_W-1], c5_reg.d[5]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lp_reg <= lp_next;
            sg_reg <= sg_next;
            c4_reg <= din;
            pv_reg <= pv_next;
            c5_reg <= c4_reg;
            ar_reg <= ar_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign dout      = ar_reg;

endmodule
`default_nettype wire

// File: rtl/cpt_numer.sv
// Stages 7-11: region select, numerator products and divider operands.
`timescale 1ns / 1ps
`default_nettype none
module cpt_numer
    import cpt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  areas_t din,
    output logic   out_valid,
    output div_t   dout
);

    typedef struct packed {
        logic [2:0]       region;
        logic             divide;
        cvec_t            base;
        cvec_t            a;
        dvec_t            m0;
        dvec_t            m1;
        logic [SC_W-1:0]  s0;
        logic [SC_W-1:0]  s1;
        logic [DEN_W-1:0] den;
    } sel_t;

    typedef struct packed {
        logic [2:0]       region;
        logic             divide;
        cvec_t            base;
        cvec_t            a;
        logic [DEN_W-1:0] den;
    } meta_t;

    typedef struct packed {
        logic [2:0][1:0][NSC-1:0][SPP_W-1:0] pp;
        logic [2:0][1:0]                     sg;
        meta_t                               mt;
    } pp_t;

    typedef struct packed {
        logic [2:0][1:0][NUM_W-1:0] pr;
        logic [DEN_W-1:0]           dm;
        logic                       dneg;
        logic                       degen;
        meta_t                      mt;
    } prd_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]      dm;
        logic                  dneg;
        logic                  degen;
        meta_t                 mt;
    } nm_t;

    sel_t       sel_next;
    sel_t       sel_reg;
    pp_t        pp_next;
    pp_t        pp_reg;
    prd_t       pr_next;
    prd_t       pr_reg;
    nm_t        nm_next;
    nm_t        nm_reg;
    div_t       dv_next;
    div_t       dv_reg;
    logic [4:0] vld_reg;

    // region tests in priority order
    always_comb
    begin
        logic [DOT_W-1:0] d1;
        logic [DOT_W-1:0] d2;
        logic [DOT_W-1:0] d3;
        logic [DOT_W-1:0] d5;
        logic [DOT_W-1:0] d6;
        d1 = din.d[0];
        d2 = din.d[1];
        d3 = din.d[2];
        d5 = din.d[4];
        d6 = din.d[5];
        sel_next.a      = din.g.a;
        sel_next.base   = din.g.a;
        sel_next.region = REG_FACE;
        sel_next.divide = 1'b0;
        sel_next.m0     = din.g.ab;
        sel_next.m1     = '0;
        sel_next.s0     = '0;
        sel_next.s1     = '0;
        sel_next.den    = '0;
        priority if ((d1[DOT_W-1] || d1 == '0) && (d2[DOT_W-1] || d2 == '0))
        begin
            sel_next.region = REG_VA;
        end
        else if (!d3[DOT_W-1] && (din.t[DD_W-1] || din.t == '0))
        begin
            sel_next.region = REG_VB;
            sel_next.base   = din.g.b;
        end
        else if ((din.vc[V_W-1] || din.vc == '0) && !d1[DOT_W-1]
                 && (d3[DOT_W-1] || d3 == '0))
        begin
            sel_next.region = REG_AB;
            sel_next.divide = 1'b1;
            sel_next.m0     = din.g.ab;
            sel_next.s0     = SC_W'($signed(d1));
            sel_next.den    = DEN_W'($signed(din.u));
        end
        else if (!d6[DOT_W-1] && (din.s[DD_W-1] || din.s == '0))
        begin
            sel_next.region = REG_VC;
            sel_next.base   = din.g.c;
        end
        else if ((din.vb[V_W-1] || din.vb == '0) && !d2[DOT_W-1]
                 && (d6[DOT_W-1] || d6 == '0))
        begin
            sel_next.region = REG_AC;
            sel_next.divide = 1'b1;
            sel_next.m0     = din.g.ac;
            sel_next.s0     = SC_W'($signed(d2));
            sel_next.den    = DEN_W'($signed(din.w));
        end
        else if ((din.va[V_W-1] || din.va == '0) && !din.t[DD_W-1] && !din.s[DD_W-1])
        begin
            sel_next.region = REG_BC;
            sel_next.divide = 1'b1;
            sel_next.base   = din.g.b;
            sel_next.m0     = din.g.bc;
            sel_next.s0     = SC_W'($signed(din.t));
            sel_next.den    = DEN_W'($signed(din.t)) + DEN_W'($signed(din.s));
        end
        else
        begin
            sel_next.region = REG_FACE;
            sel_next.divide = 1'b1;
            sel_next.m0     = din.g.ab;
            sel_next.s0     = din.vb;
            sel_next.m1     = din.g.ac;
            sel_next.s1     = din.vc;
            sel_next.den    = din.va + din.vb + din.vc;
        end
    end

    // vector * scalar as limb products on magnitudes
    always_comb
    begin
        logic [1:0][SC_W-1:0] ms;
        logic [DF_W-1:0]      mm;
        logic [DF_W-1:0]      mv;
        logic [SC_W-1:0]      sv;
        for (int j = 0; j < 2; j++)
        begin
            sv    = (j == 0) ? sel_reg.s0 : sel_reg.s1;
            ms[j] = sv[SC_W-1] ? -sv : sv;
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                mv = (j == 0) ? sel_reg.m0[k] : sel_reg.m1[k];
                sv = (j == 0) ? sel_reg.s0 : sel_reg.s1;
                mm = mv[DF_W-1] ? -mv : mv;
                pp_next.sg[k][j] = mv[DF_W-1] ^ sv[SC_W-1];
                for (int i = 0; i < NSC; i++)
                begin
                    pp_next.pp[k][j][i] = SPP_W'(mm) * SPP_W'(ms[j][i*SCL +: SCL]);
                end
            end
        end
        pp_next.mt.region = sel_reg.region;
        pp_next.mt.divide = sel_reg.divide;
        pp_next.mt.base   = sel_reg.base;
        pp_next.mt.a      = sel_reg.a;
        pp_next.mt.den    = sel_reg.den;
    end

    always_comb
    begin
        logic [SP_W-1:0] acc;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                acc = '0;
                for (int i = 0; i < NSC; i++)
                begin
                    acc = acc + (SP_W'(pp_reg.pp[k][j][i]) << (SCL * i));
                end
                pr_next.pr[k][j] = pp_reg.sg[k][j] ? -NUM_W'(acc) : NUM_W'(acc);
            end
        end
        pr_next.dneg  = pp_reg.mt.den[DEN_W-1];
        pr_next.dm    = pp_reg.mt.den[DEN_W-1] ? -pp_reg.mt.den : pp_reg.mt.den;
        pr_next.degen = pp_reg.mt.divide && (pp_reg.mt.den == '0);
        pr_next.mt    = pp_reg.mt;
    end

    // a zero divisor falls back to vertex A with no division
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nm_next.num[k] = pr_reg.pr[k][0] + pr_reg.pr[k][1];
        end
        nm_next.dm    = pr_reg.dm;
        nm_next.dneg  = pr_reg.dneg;
        nm_next.degen = pr_reg.degen;
        nm_next.mt    = pr_reg.mt;
        if (pr_reg.degen)
        begin
            nm_next.mt.base   = pr_reg.mt.a;
            nm_next.mt.divide = 1'b0;
        end
    end

    // round to nearest, ties away: floor((2|n| + |d|) / (2|d|))
    always_comb
    begin
        logic [NUM_W-1:0] na;
        for (int k = 0; k < 3; k++)
        begin
            na             = nm_reg.num[k][NUM_W-1] ? -nm_reg.num[k] : nm_reg.num[k];
            dv_next.r[k]   = (R_W'(na) << 1) + R_W'(nm_reg.dm);
            dv_next.neg[k] = nm_reg.num[k][NUM_W-1] ^ nm_reg.dneg;
        end
        dv_next.q      = '0;
        dv_next.ovf    = '0;
        dv_next.dq     = {nm_reg.dm, 1'b0};
        dv_next.base   = nm_reg.mt.base;
        dv_next.region = nm_reg.mt.region;
        dv_next.divide = nm_reg.mt.divide;
        dv_next.degen  = nm_reg.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_reg <= sel_next;
            pp_reg  <= pp_next;
            pr_reg  <= pr_next;
            nm_reg  <= nm_next;
            dv_reg  <= dv_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign dout      = dv_reg;

endmodule
`default_nettype wire

// File: rtl/cpt_divider.sv
// Pipelined restoring divider, one quotient bit per stage, and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module cpt_divider
    import cpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  div_t din,
    output logic out_valid,
    output res_t res
);

    div_t          src [QB];
    div_t          st_next [QB];
    div_t          st_reg [QB];
    logic [QB-1:0] vld_reg;
    res_t          res_next;
    res_t          res_reg;
    logic          vld_out_reg;

    always_comb
    begin
        src[0] = din;
        for (int j = 1; j < QB; j++)
        begin
            src[j] = st_reg[j-1];
        end
    end

    // stage j settles quotient bit QB-1-j; the first stage also flags |q| >= 2^QB
    always_comb
    begin
        logic [R_W-1:0] shd;
        for (int j = 0; j < QB; j++)
        begin
            st_next[j] = src[j];
            for (int k = 0; k < 3; k++)
            begin
                if (j == 0)
                begin
                    st_next[j].ovf[k] = src[j].r[k] >= (R_W'(src[j].dq) << QB);
                end
                shd = R_W'(src[j].dq) << (QB - 1 - j);
                if (src[j].r[k] >= shd)
                begin
                    st_next[j].r[k]            = src[j].r[k] - shd;
                    st_next[j].q[k][QB-1-j]    = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [OS_W-1:0] qv;
        logic [OS_W-1:0] sum;
        div_t            fin;
        fin = st_reg[QB-1];
        for (int k = 0; k < 3; k++)
        begin
            qv  = OS_W'(fin.q[k]);
            qv  = fin.neg[k] ? -qv : qv;
            sum = OS_W'($signed(fin.base[k])) + qv;
            if (!fin.divide)
                res_next.near[k] = fin.base[k];
            else if (fin.ovf[k])
                res_next.near[k] = fin.neg[k] ? CMIN : CMAX;
            else if (sum[OS_W-1:CW-1] != {(OS_W-CW+1){sum[OS_W-1]}})
                res_next.near[k] = sum[OS_W-1] ? CMIN : CMAX;
            else
                res_next.near[k] = sum[CW-1:0];
        end
        res_next.region  = fin.region;
        res_next.in_face = (fin.region == REG_FACE);
        res_next.degen   = fin.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[QB-2:0], in_valid};
            vld_out_reg <= vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < QB; j++)
            begin
                st_reg[j] <= st_next[j];
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_out_reg;
    assign res       = res_reg;

    a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
        vld_out_reg && res_reg.degen |-> res_reg.region == REG_AB
            || res_reg.region == REG_AC || res_reg.region == REG_BC
            || res_reg.region == REG_FACE)
        else $error("degenerate flag on a vertex region");

    a_face_flag: assert property (@(posedge clk) disable iff (!rst_n)
        vld_out_reg |-> res_reg.in_face == (res_reg.region == REG_FACE))
        else $error("face flag disagrees with region");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(vld_out_reg))
        else $error("pipeline moved while frozen");

endmodule
`default_nettype wire

// File: rtl/closest_point_on_triangle_core.sv
// Top level of the closest-point-on-triangle pipeline.
// Accepts one query transaction (point P, vertices A, B, C in signed Q16.16) per clock
// while in_stall is low and returns the nearest point of triangle ABC, its Voronoi
// region and the face and degenerate flags. All products and sums are exact; the one
// division per coordinate is rounded to nearest with ties away from zero, and results
// saturate to the 32-bit range. Throughput is one transaction per cycle unless stalled;
// the pipeline is 3 dot-product stages, 3 area stages, 5 numerator stages, 35 divider
// stages (one quotient bit each) and the output register. When the output is stalled
// with a result present, the whole pipeline holds and in_stall is raised in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_triangle_core
    import cpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CW-1:0] query_x,
    input  logic signed [CW-1:0] query_y,
    input  logic signed [CW-1:0] query_z,
    input  logic signed [CW-1:0] vert_a_x,
    input  logic signed [CW-1:0] vert_a_y,
    input  logic signed [CW-1:0] vert_a_z,
    input  logic signed [CW-1:0] vert_b_x,
    input  logic signed [CW-1:0] vert_b_y,
    input  logic signed [CW-1:0] vert_b_z,
    input  logic signed [CW-1:0] vert_c_x,
    input  logic signed [CW-1:0] vert_c_y,
    input  logic signed [CW-1:0] vert_c_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [CW-1:0] near_x,
    output logic signed [CW-1:0] near_y,
    output logic signed [CW-1:0] near_z,
    output logic [2:0]           region,
    output logic                 inside_face,
    output logic                 degenerate
);

    logic   adv;
    cvec_t  p;
    cvec_t  a;
    cvec_t  b;
    cvec_t  c;
    logic   dots_valid;
    dots_t  dots;
    logic   areas_valid;
    areas_t areas;
    logic   numer_valid;
    div_t   numer;
    res_t   res;

    // a result waiting on a stalled consumer freezes every stage
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign p = {query_z, query_y, query_x};
    assign a = {vert_a_z, vert_a_y, vert_a_x};
    assign b = {vert_b_z, vert_b_y, vert_b_x};
    assign c = {vert_c_z, vert_c_y, vert_c_x};

    cpt_dots u_dots (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .p         (p),
        .a         (a),
        .b         (b),
        .c         (c),
        .out_valid (dots_valid),
        .dout      (dots)
    );

    cpt_areas u_areas (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dots_valid),
        .din       (dots),
        .out_valid (areas_valid),
        .dout      (areas)
    );

    cpt_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (areas_valid),
        .din       (areas),
        .out_valid (numer_valid),
        .dout      (numer)
    );

    cpt_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (numer_valid),
        .din       (numer),
        .out_valid (out_valid),
        .res       (res)
    );

    assign near_x      = res.near[0];
    assign near_y      = res.near[1];
    assign near_z      = res.near[2];
    assign region      = res.region;
    assign inside_face = res.in_face;
    assign degenerate  = res.degen;

endmodule
`default_nettype wire
